@@ sv/teq_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer expiry queue package
// Shared widths, codes, state type and the structs that pass between the
// controller and the chain of timer cells.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int OP_W        = 2;
    localparam int HANDLE_W    = 4;
    localparam int TIMEOUT_W   = 32;
    localparam int TIME_W      = 63;
    localparam int STATUS_W    = 2;
    localparam int REM_W       = 32;
    localparam int ORDER_W     = 32;
    localparam int HANDLE_LIMIT = 2 ** HANDLE_W;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_OUT        = 16;
    localparam int CNT_W          = $clog2(MAX_OUT + 1);
    localparam int BUF_IDX_W      = $clog2(MAX_OUT);

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [REM_W-1:0]  REM_EMPTY = '1;
    localparam logic [REM_W-1:0]  REM_SAT   = {1'b0, {(REM_W-1){1'b1}}};

    localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LAUNCH,
        S_WAIT,
        S_EMIT,
        S_RESP
    } state_t;

    // Token that travels down the chain, one cell per cycle
    typedef struct packed {
        logic                tok;
        logic                due_v;
        logic [TIME_W-1:0]   due_exp;
        logic [ORDER_W-1:0]  due_age;
        logic [HANDLE_W-1:0] due_handle;
        logic                any_v;
        logic [TIME_W-1:0]   min_exp;
    } scan_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic                wr_en;
        logic                clr_en;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   expiry;
        logic [ORDER_W-1:0]  order;
    } cmd_t;

endpackage

@@ sv/teq_if.sv @@
// ----------------------------------------------------------------------------
// Timer expiry queue channels
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface teq_in_if;
    import teq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [HANDLE_W-1:0]  timer_handle;
    logic signed [TIMEOUT_W-1:0] timeout_ms;
    logic [TIME_W-1:0]    now_ms;

    modport source (output valid, operation, timer_handle, timeout_ms, now_ms, input ready);
    modport sink   (input valid, operation, timer_handle, timeout_ms, now_ms, output ready);
endinterface

interface teq_out_if;
    import teq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [HANDLE_W-1:0]  expired_handle;
    logic signed [REM_W-1:0] remaining_ms;
    logic                 last;

    modport source (output valid, status, expired_handle, remaining_ms, last, input ready);
    modport sink   (input valid, status, expired_handle, remaining_ms, last, output ready);
endinterface

@@ sv/teq_cell.sv @@
// ----------------------------------------------------------------------------
// Timer expiry queue cell
// One timer slot: holds pending, expiry and arming order, and folds its entry
// into the scan token before handing it to the next cell.
// ----------------------------------------------------------------------------
module teq_cell #(
    parameter int IDX = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  teq_pkg::cmd_t                  cmd,
    input  logic [teq_pkg::TIME_W-1:0]     now,
    input  logic [teq_pkg::ORDER_W-1:0]    counter,
    input  teq_pkg::scan_t                 scan_in,
    output teq_pkg::scan_t                 scan_out,
    output logic                           hit_pend
);
    import teq_pkg::*;

    logic                pend_reg;
    logic                pend_next;
    logic [TIME_W-1:0]   exp_reg;
    logic [ORDER_W-1:0]  order_reg;
    logic                hit;
    logic                due;
    logic [ORDER_W-1:0]  age;
    scan_t               scan_next;
    scan_t               scan_out_reg;

    assign hit      = (IDX < HANDLE_LIMIT) && (cmd.handle == HANDLE_W'(IDX));
    assign hit_pend = hit && pend_reg;
    assign due      = pend_reg && (exp_reg <= now);
    assign age      = counter - order_reg;

    always_comb
    begin
        pend_next = pend_reg;
        if (cmd.wr_en && hit)
        begin
            pend_next = 1'b1;
        end
        else if (cmd.clr_en && hit)
        begin
            pend_next = 1'b0;
        end
    end

    // Fold this entry: earliest due first, older arm wins a tie
    always_comb
    begin
        scan_next = scan_in;
        if (due && (!scan_in.due_v || (exp_reg < scan_in.due_exp) ||
            ((exp_reg == scan_in.due_exp) && (age > scan_in.due_age))))
        begin
            scan_next.due_v      = 1'b1;
            scan_next.due_exp    = exp_reg;
            scan_next.due_age    = age;
            scan_next.due_handle = HANDLE_W'(IDX);
        end
        if (pend_reg && (!scan_in.any_v || (exp_reg < scan_in.min_exp)))
        begin
            scan_next.any_v   = 1'b1;
            scan_next.min_exp = exp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= 1'b0;
            scan_out_reg <= '0;
        end
        else
        begin
            pend_reg     <= pend_next;
            scan_out_reg <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && hit)
        begin
            exp_reg   <= cmd.expiry;
            order_reg <= cmd.order;
        end
    end

    assign scan_out = scan_out_reg;

endmodule

@@ sv/timer_expiry_queue.sv @@
// Arm, cancel and other commands offer their result after one scan of the chain,
// which passes the token through every cell register in turn.
// Tick with m due handles runs m+1 scans and offers the first result after the last,
// then one per cycle while the sink is ready. One transaction
// at a time: input reopens once the last result is loaded into the output register.
// Reset (rst_n, asynchronous, active low) empties the table, clears the arm counter
// ----------------------------------------------------------------------------
// Timer expiry queue
// Table of one-shot timers held in a chain of cells, one cell per handle.
// The controller broadcasts arm and cancel commands, and sends a scan token
// down the chain to find the earliest due timer and the nearest expiry.
// Reset also drops any result in flight.
// ----------------------------------------------------------------------------
module timer_expiry_queue #(
    parameter int NUM_TIMERS = teq_pkg::NUM_TIMERS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    teq_in_if.sink        in_ch,
    teq_out_if.source     out_ch
);
    import teq_pkg::*;

    // Control state
    state_t              state_reg;
    state_t              state_next;
    logic [ORDER_W-1:0]  counter_reg;
    logic [ORDER_W-1:0]  counter_next;
    logic [CNT_W-1:0]    n_reg;
    logic [CNT_W-1:0]    n_next;
    logic [CNT_W-1:0]    k_reg;
    logic [CNT_W-1:0]    k_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    // Held transaction and working payload
    logic [OP_W-1:0]      op_reg;
    logic [HANDLE_W-1:0]  handle_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     rem_next;
    logic [HANDLE_W-1:0]  hbuf_reg [MAX_OUT];
    logic                 hbuf_we;

    logic [STATUS_W-1:0]  out_status_reg;
    logic [STATUS_W-1:0]  out_status_next;
    logic [HANDLE_W-1:0]  out_handle_reg;
    logic [HANDLE_W-1:0]  out_handle_next;
    logic [REM_W-1:0]     out_rem_reg;
    logic [REM_W-1:0]     out_rem_next;
    logic                 out_last_reg;
    logic                 out_last_next;

    // Chain wiring
    cmd_t                 cmd;
    scan_t                chain [NUM_TIMERS+1];
    scan_t                tail;
    logic [NUM_TIMERS-1:0] hit_pend;

    logic                 accept;
    logic                 out_free;
    logic                 in_range;
    logic                 tick_more;
    logic [TIME_W:0]      arm_sum;
    logic [TIME_W-1:0]    arm_exp;
    logic [TIME_W-1:0]    rem_diff;
    logic [REM_W-1:0]     rem_calc;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign in_range    = (32'(handle_reg) < NUM_TIMERS);
    assign tail        = chain[NUM_TIMERS];

    // Clamp a negative timeout to zero, saturate the expiry at the top of time
    assign arm_sum = {1'b0, now_reg} +
                     {{(TIME_W-TIMEOUT_W+2){1'b0}},
                      (timeout_reg[TIMEOUT_W-1] ? {(TIMEOUT_W-1){1'b0}}
                                                : timeout_reg[TIMEOUT_W-2:0])};
    assign arm_exp = arm_sum[TIME_W] ? TIME_MAX : arm_sum[TIME_W-1:0];

    // Time left to the nearest pending expiry, from the token at the tail
    assign rem_diff = tail.min_exp - now_reg;
    always_comb
    begin
        if (!tail.any_v)
        begin
            rem_calc = REM_EMPTY;
        end
        else if (tail.min_exp <= now_reg)
        begin
            rem_calc = '0;
        end
        else if (rem_diff > TIME_W'(REM_SAT))
        begin
            rem_calc = REM_SAT;
        end
        else
        begin
            rem_calc = rem_diff[REM_W-1:0];
        end
    end

    assign tick_more = (op_reg == OP_TICK) && tail.due_v && (n_reg < CNT_W'(MAX_OUT));

    // Inject a fresh token only while launching a scan
    always_comb
    begin
        chain[0]     = '0;
        chain[0].tok = (state_reg == S_LAUNCH);
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++)
        begin : g_cell
            teq_cell #(
                .IDX (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .now      (now_reg),
                .counter  (counter_reg),
                .scan_in  (chain[gi]),
                .scan_out (chain[gi+1]),
                .hit_pend (hit_pend[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        counter_next    = counter_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        status_next     = status_reg;
        rem_next        = rem_reg;
        hbuf_we         = 1'b0;
        cmd             = '0;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        out_rem_next    = out_rem_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // Apply arm or cancel; the scan launched next sees the new table
                cmd.handle  = handle_reg;
                cmd.expiry  = arm_exp;
                cmd.order   = counter_reg;
                status_next = ST_DONE;
                n_next      = '0;
                unique case (op_reg)
                    OP_ARM:
                    begin
                        cmd.wr_en = 1'b1;
                        if (in_range)
                        begin
                            counter_next = counter_reg + ORDER_W'(1);
                        end
                    end
                    OP_CANCEL:
                    begin
                        cmd.clr_en  = 1'b1;
                        status_next = (|hit_pend) ? ST_DONE : ST_NOT_FOUND;
                    end
                    OP_TICK:
                    begin
                        status_next = ST_NONE_DUE;
                    end
                    default:
                    begin
                        status_next = ST_DONE;
                    end
                endcase
                state_next = S_LAUNCH;
            end
            S_LAUNCH:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (tail.tok)
                begin
                    if (tick_more)
                    begin
                        // Retire the winner and scan again
                        cmd.clr_en = 1'b1;
                        cmd.handle = tail.due_handle;
                        hbuf_we    = 1'b1;
                        n_next     = n_reg + CNT_W'(1);
                        state_next = S_LAUNCH;
                    end
                    else
                    begin
                        rem_next = rem_calc;
                        k_next   = '0;
                        if ((op_reg == OP_TICK) && (n_reg != '0))
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_DONE;
                    out_handle_next = hbuf_reg[k_reg[BUF_IDX_W-1:0]];
                    out_rem_next    = rem_reg;
                    out_last_next   = (k_reg == (n_reg - CNT_W'(1)));
                    k_next          = k_reg + CNT_W'(1);
                    if (k_reg == (n_reg - CNT_W'(1)))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_handle_next = '0;
                    out_rem_next    = rem_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            counter_reg   <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= in_ch.operation;
            handle_reg  <= in_ch.timer_handle;
            timeout_reg <= in_ch.timeout_ms;
            now_reg     <= in_ch.now_ms;
        end
        if (hbuf_we)
        begin
            hbuf_reg[n_reg[BUF_IDX_W-1:0]] <= tail.due_handle;
        end
        status_reg     <= status_next;
        rem_reg        <= rem_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
        out_rem_reg    <= out_rem_next;
        out_last_reg   <= out_last_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = out_status_reg;
    assign out_ch.expired_handle = out_handle_reg;
    assign out_ch.remaining_ms   = out_rem_reg;
    assign out_ch.last           = out_last_reg;

endmodule

@@ sv/teq_checker.sv @@
// ----------------------------------------------------------------------------
// Timer expiry queue checker
// Port-level assertions on command and result transactions.
// ----------------------------------------------------------------------------
module teq_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [teq_pkg::STATUS_W-1:0]     out_status,
    input  logic [teq_pkg::HANDLE_W-1:0]     out_handle,
    input  logic signed [teq_pkg::REM_W-1:0] out_rem,
    input  logic                             out_last
);
    import teq_pkg::*;

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status) &&
        $stable(out_handle) && $stable(out_rem) && $stable(out_last))
        else $error("result changed while stalled");

    // One command transaction at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command taken while previous one still in work");

    // Not-found and none-due results are single and carry no handle
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == ST_NOT_FOUND || out_status == ST_NONE_DUE)
        |-> out_last && (out_handle == '0))
        else $error("non-expiry result malformed");

    // Only minus one may be negative
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_rem[REM_W-1] |-> (out_rem == -1))
        else $error("remaining time out of range");

    // Nothing due means the nearest expiry lies ahead or the table is empty
    a_none_due_rem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == ST_NONE_DUE) |-> (out_rem != 0))
        else $error("tick found none due but a timer is overdue");

endmodule

bind timer_expiry_queue teq_checker u_teq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_handle (out_ch.expired_handle),
    .out_rem    (out_ch.remaining_ms),
    .out_last   (out_ch.last)
);

@@ tb/sv/timer_expiry_queue_test.sv @@
// ----------------------------------------------------------------------------
// Timer expiry queue testbench
// Drives arm, cancel and tick transactions into the timer table. Each
// accepted transaction goes through a behavioural copy of the table, and
// the answers that come back are compared in order, field by field.
// Both channels idle and stall in random bursts, and once the receiver
// holds off long enough to stall the input channel.
// ----------------------------------------------------------------------------
module timer_expiry_queue_test;
    import teq_pkg::*;

    localparam int NUM       = NUM_TIMERS_DEF;
    localparam int RAND_CMDS = 280;
    localparam int LIMIT     = 1000000;
    localparam int SETTLE    = 64;
    localparam int HOLD_OFF  = 400;

    // No code of the package names the fourth operation; it must do nothing
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [HANDLE_W-1:0]  handle;
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [TIME_W-1:0]    now_ms;
    } command_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [REM_W-1:0]    remaining;
        logic                last;
    } answer_t;

    logic clk;
    logic rst_n;

    teq_in_if  in_ch ();
    teq_out_if out_ch ();

    timer_expiry_queue u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Commands waiting to be offered, and answers the table owes us
    command_t command_q[$];
    answer_t  answer_q[$];
    command_t offered;

    // Behavioural copy of the timer table
    logic                 tmr_pending [NUM] = '{default: 1'b0};
    logic [TIME_W-1:0]    tmr_expiry  [NUM] = '{default: '0};
    logic [ORDER_W-1:0]   tmr_order   [NUM] = '{default: '0};
    logic [ORDER_W-1:0]   arm_count = '0;

    int errors = 0;
    int accepted;
    int total_cmds;
    int cycles = 0;
    int results_seen = 0;
    int n_arm = 0, n_cancel = 0, n_tick = 0, n_other = 0, n_expired = 0, widest_tick = 0;

    // Idling controls; the idle rates and quiet are set by the stimulus process as the run moves on
    int send_idle_pct;
    int recv_idle_pct;
    bit quiet;
    int send_gap;
    int recv_gap;
    int hold_cnt;
    bit hold_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Time left to the nearest pending expiry: all ones when empty,
    // zero when overdue, saturated at the largest positive value
    function automatic logic [REM_W-1:0] time_left(input logic [TIME_W-1:0] now);
        logic              any;
        logic [TIME_W-1:0] best;
        logic [TIME_W-1:0] diff;
        any  = 1'b0;
        best = '0;
        for (int i = 0; i < NUM; i++)
        begin
            if (tmr_pending[i] && (!any || tmr_expiry[i] < best))
            begin
                best = tmr_expiry[i];
                any  = 1'b1;
            end
        end
        if (!any)
            return REM_EMPTY;
        if (best <= now)
            return '0;
        diff = best - now;
        if (diff > {{(TIME_W-REM_W){1'b0}}, REM_SAT})
            return REM_SAT;
        return diff[REM_W-1:0];
    endfunction

    // Apply one accepted command to the table and queue the answers it owes
    task automatic timer_table_update(input command_t c);
        logic [TIME_W:0]      sum;
        logic [ORDER_W-1:0]   age;
        logic [ORDER_W-1:0]   sel_age;
        logic [REM_W-1:0]     rem;
        logic [STATUS_W-1:0]  status;
        int                   sel;
        int                   n;
        int                   picked[MAX_OUT];
        bit                   searching;
        answer_t              ans;
        status = ST_DONE;
        case (c.op)
            OP_ARM:
            begin
                n_arm++;
                // Clamp a negative delay to zero, saturate the sum at the top of time
                sum = {1'b0, c.now_ms};
                if (!c.timeout_ms[TIMEOUT_W-1])
                    sum = sum + {{(TIME_W+1-TIMEOUT_W){1'b0}}, c.timeout_ms};
                tmr_expiry[c.handle]  = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
                tmr_pending[c.handle] = 1'b1;
                tmr_order[c.handle]   = arm_count;
                arm_count             = arm_count + 1'b1;
            end
            OP_CANCEL:
            begin
                n_cancel++;
                if (tmr_pending[c.handle])
                    tmr_pending[c.handle] = 1'b0;
                else
                    status = ST_NOT_FOUND;
            end
            OP_TICK:
            begin
                n_tick++;
                n = 0;
                searching = 1'b1;
                // Take due timers one at a time: earliest expiry, then oldest arm
                while (searching && n < MAX_OUT)
                begin
                    sel = -1;
                    sel_age = '0;
                    for (int i = 0; i < NUM; i++)
                    begin
                        if (tmr_pending[i] && tmr_expiry[i] <= c.now_ms)
                        begin
                            age = arm_count - tmr_order[i];
                            if (sel < 0 || tmr_expiry[i] < tmr_expiry[sel] ||
                                (tmr_expiry[i] == tmr_expiry[sel] && age > sel_age))
                            begin
                                sel = i;
                                sel_age = age;
                            end
                        end
                    end
                    if (sel < 0)
                        searching = 1'b0;
                    else
                    begin
                        tmr_pending[sel] = 1'b0;
                        picked[n] = sel;
                        n++;
                    end
                end
                rem = time_left(c.now_ms);
                if (n == 0)
                begin
                    ans = '{ST_NONE_DUE, '0, rem, 1'b1};
                    answer_q.insert(answer_q.size(), ans);
                end
                else
                begin
                    for (int k = 0; k < n; k++)
                    begin
                        ans = '{ST_DONE, picked[k][HANDLE_W-1:0], rem, k == n - 1};
                        answer_q.insert(answer_q.size(), ans);
                    end
                    n_expired += n;
                    if (n > widest_tick)
                        widest_tick = n;
                end
            end
            default:
                n_other++;
        endcase
        if (c.op != OP_TICK)
        begin
            ans = '{status, '0, time_left(c.now_ms), 1'b1};
            answer_q.insert(answer_q.size(), ans);
        end
    endtask

    task automatic push_cmd(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h,
                            input logic [TIMEOUT_W-1:0] to, input logic [TIME_W-1:0] now);
        command_t c;
        c = '{op, h, to, now};
        command_q.insert(command_q.size(), c);
        total_cmds++;
    endtask

    function automatic logic [TIMEOUT_W-1:0] pick_timeout();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(40);
        if (r < 80)
            return {1'b1, 31'($urandom)};
        if (r < 90)
            return $urandom;
        return 32'h7FFF_FFFF - $urandom_range(20);
    endfunction

    task automatic check_field(input string name, input logic [REM_W-1:0] want,
                               input logic [REM_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Command driver: offer the next queued command, hold it until accepted,
    // insert idle bursts between transactions unless the run has gone quiet
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.operation    <= '0;
            in_ch.timer_handle <= '0;
            in_ch.timeout_ms   <= '0;
            in_ch.now_ms       <= '0;
            send_gap           <= 0;
            accepted           <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                timer_table_update(offered);
                accepted <= accepted + 1;
            end
            // Advance only when nothing is left waiting on the channel
            if (!(in_ch.valid && !in_ch.ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap    <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (command_q.size() == 0)
                    in_ch.valid <= 1'b0;
                else if (!quiet && $urandom_range(99) < send_idle_pct)
                begin
                    send_gap    <= $urandom_range(12);
                    in_ch.valid <= 1'b0;
                end
                else
                begin
                    offered             = command_q[0];
                    command_q.delete(0);
                    in_ch.operation    <= offered.op;
                    in_ch.timer_handle <= offered.handle;
                    in_ch.timeout_ms   <= offered.timeout_ms;
                    in_ch.now_ms       <= offered.now_ms;
                    in_ch.valid        <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result back-pressure: random stall bursts, plus one long hold-off once
    // enough commands have gone in, so the table stops taking new commands
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_gap     <= 0;
            hold_cnt     <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt     <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!hold_done && accepted >= 60)
        begin
            hold_done    <= 1'b1;
            hold_cnt     <= HOLD_OFF;
            out_ch.ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap     <= recv_gap - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(99) < recv_idle_pct)
        begin
            recv_gap     <= $urandom_range(12);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Result checker: every transaction on the result channel must match the
    // oldest answer still owed
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (answer_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %0d handle %0d",
                         $time, out_ch.status, out_ch.expired_handle);
            end
            else
            begin
                answer_t want;
                want = answer_q[0];
                answer_q.delete(0);
                check_field("status", REM_W'(want.status), REM_W'(out_ch.status));
                check_field("expired_handle", REM_W'(want.handle), REM_W'(out_ch.expired_handle));
                check_field("remaining_ms", want.remaining, out_ch.remaining_ms);
                check_field("last", REM_W'(want.last), REM_W'(out_ch.last));
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("%0t: timeout with %0d results still owed", $time, answer_q.size());
            $display("FAIL timer_expiry_queue");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        logic [TIME_W-1:0] wall_ms;
        int                perm[NUM];
        int                tmp, j, pick, steps;

        total_cmds = 0;
        send_idle_pct = 30; recv_idle_pct = 30; quiet = 1'b0;

        rst_n = 1'b0;

        // Directed: empty table, not-found cancel, unused operation
        push_cmd(OP_TICK, 0, 0, 0);
        push_cmd(OP_CANCEL, 5, 0, 0);
        push_cmd(OP_UNUSED, 15, 32'hFFFF_FFFF, TIME_MAX);
        // Negative delays clamp to zero; re-arm replaces the old entry
        push_cmd(OP_ARM, 0, 32'h8000_0000, 100);
        push_cmd(OP_ARM, 15, 32'h7FFF_FFFF, 100);
        push_cmd(OP_ARM, 3, 10, 100);
        push_cmd(OP_ARM, 3, 0, 100);
        push_cmd(OP_ARM, 7, 32'hFFFF_FFFF, 100);
        push_cmd(OP_CANCEL, 15, 0, 100);
        push_cmd(OP_CANCEL, 15, 0, 100);
        // One short of due, then three equal expiries in arming order
        push_cmd(OP_TICK, 0, 0, 99);
        push_cmd(OP_TICK, 0, 0, 100);
        // Expiry saturates at the top of time; remaining reaches its saturation value too
        push_cmd(OP_ARM, 1, 5, TIME_MAX - 63'd2);
        push_cmd(OP_ARM, 2, 32'h7FFF_FFFF, 0);
        push_cmd(OP_TICK, 0, 0, 0);
        push_cmd(OP_ARM, 4, 1, 63'h100_0000_0000);
        push_cmd(OP_TICK, 0, 0, 5);
        push_cmd(OP_CANCEL, 4, 0, 5);
        push_cmd(OP_TICK, 0, 0, TIME_MAX);
        push_cmd(OP_TICK, 0, 0, TIME_MAX);

        // Random: mostly timer sessions against an advancing clock, some
        // full-table ticks, and some free noise
        wall_ms = 1000;
        while (total_cmds < RAND_CMDS)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(9) == 0)
                wall_ms = {31'($urandom), $urandom};
            else if ($urandom_range(19) == 0)
                wall_ms = TIME_MAX - $urandom_range(100);
            if (pick < 65)
            begin
                steps = $urandom_range(1, 8);
                for (int k = 0; k < steps; k++)
                    push_cmd(OP_ARM, HANDLE_W'($urandom_range(NUM - 1)), pick_timeout(),
                             wall_ms + $urandom_range(5));
                steps = $urandom_range(2, 6);
                for (int k = 0; k < steps; k++)
                begin
                    tmp = $urandom_range(99);
                    if (tmp < 60)
                    begin
                        wall_ms = wall_ms + $urandom_range(40);
                        push_cmd(OP_TICK, HANDLE_W'($urandom), $urandom, wall_ms);
                    end
                    else if (tmp < 85)
                        push_cmd(OP_CANCEL, HANDLE_W'($urandom_range(NUM - 1)), $urandom,
                                 wall_ms);
                    else
                        push_cmd(OP_ARM, HANDLE_W'($urandom_range(NUM - 1)), pick_timeout(),
                                 wall_ms);
                end
            end
            else if (pick < 80)
            begin
                // Fill the whole table with near-equal expiries, then drain it
                for (int i = 0; i < NUM; i++)
                    perm[i] = i;
                for (int i = NUM - 1; i > 0; i--)
                begin
                    j = $urandom_range(i);
                    tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
                end
                for (int i = 0; i < NUM; i++)
                    push_cmd(OP_ARM, HANDLE_W'(perm[i]), $urandom_range(3), wall_ms);
                wall_ms = wall_ms + 5;
                push_cmd(OP_TICK, 0, 0, wall_ms);
            end
            else
            begin
                steps = $urandom_range(1, 3);
                for (int k = 0; k < steps; k++)
                    push_cmd(OP_W'($urandom_range(3)), HANDLE_W'($urandom), $urandom,
                             {31'($urandom), $urandom});
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Vary the idling: moderate, none at all, light sending with heavier receive stalls, then quiet to the end
        while (accepted < 100)
            @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (accepted < 140)
            @(posedge clk);
        send_idle_pct = 15;
        recv_idle_pct = 40;
        while (command_q.size() > 40)
            @(posedge clk);
        quiet = 1'b1;

        while (accepted < total_cmds || answer_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Ran %0d commands: %0d arms, %0d cancels, %0d ticks, %0d unused operations",
                 accepted, n_arm, n_cancel, n_tick, n_other);
        $display("Checked %0d results; %0d timers expired, widest tick gave %0d",
                 results_seen, n_expired, widest_tick);
        if (errors == 0)
            $display("PASS timer_expiry_queue");
        else
            $display("FAIL timer_expiry_queue");
        $finish;
    end

endmodule
